// ----- hdl/hids_pkg.sv -----
package hids_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [63:0] HASH_SEED = 64'd2166136261;
    localparam logic [23:0] HASH_MULT = 24'd8494653;

    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef struct packed {
        op_t op;
        logic invalid;
        logic [63:0] hash;
    } job_t;

endpackage

// ----- hdl/hashed_identifier_set.sv -----
// Channel   Signals                                  Handshake
// input     req_type, key_char, key_last             taken when start is high and busy is low
// result    found, key_invalid, table_full, key_hash shown for one cycle while done is high
//
// A character is taken in FE_IDLE, where the split 64-bit hash multiply is registered, and is
// finished in FE_FINISH; no new one is taken before FE_IDLE. A key end goes via a two-entry
// queue to the back end: an insert or clear is handled in BE_IDLE, and a lookup scans the used
// slots through one memory read port until a match or the last one. A clear only resets the
// fill count, so no sweep. Reset is asynchronous and active low; busy is high in FE_FINISH or
// while the queue is full. The receiver cannot stall; each result item is present for exactly one cycle.
module hashed_identifier_set (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  logic [1:0] req_type,
    input  logic [7:0] key_char,
    input  logic key_last,
    output logic done,
    output logic found,
    output logic key_invalid,
    output logic table_full,
    output logic [63:0] key_hash
);

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    hids_pkg::job_t push_job;
    hids_pkg::job_t head_job;

    hids_front u_front (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req_type(req_type),
        .key_char(key_char),
        .key_last(key_last),
        .q_full(q_full),
        .q_push(q_push),
        .q_job(push_job)
    );

    hids_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(q_push),
        .push_job(push_job),
        .pop(q_pop),
        .full(q_full),
        .empty(q_empty),
        .head_job(head_job)
    );

    hids_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_empty(q_empty),
        .q_job(head_job),
        .q_pop(q_pop),
        .done(done),
        .found(found),
        .key_invalid(key_invalid),
        .table_full(table_full),
        .key_hash(key_hash)
    );

endmodule

// ----- hdl/hids_queue.sv -----
module hids_queue (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  hids_pkg::job_t push_job,
    input  logic pop,
    output logic full,
    output logic empty,
    output hids_pkg::job_t head_job
);

    hids_pkg::job_t slot_reg [hids_pkg::QUEUE_DEPTH];
    logic [hids_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [hids_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [hids_pkg::QCNT_W-1:0] cnt_reg;
    logic do_push;
    logic do_pop;

    assign full = (cnt_reg == hids_pkg::QCNT_W'(hids_pkg::QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head_job = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && !empty;

    always_ff @(posedge clk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                if (wr_ptr_reg == hids_pkg::QPTR_W'(hids_pkg::QUEUE_DEPTH - 1)) begin
                    wr_ptr_reg <= '0;
                end else begin
                    wr_ptr_reg <= wr_ptr_reg + 1'b1;
                end
            end
            if (do_pop) begin
                if (rd_ptr_reg == hids_pkg::QPTR_W'(hids_pkg::QUEUE_DEPTH - 1)) begin
                    rd_ptr_reg <= '0;
                end else begin
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                end
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/hids_front.sv -----
module hids_front (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  logic [1:0] req_type,
    input  logic [7:0] key_char,
    input  logic key_last,
    input  logic q_full,
    output logic q_push,
    output hids_pkg::job_t q_job
);

    typedef enum logic [1:0] {
        FE_IDLE = 2'b01,
        FE_FINISH = 2'b10
    } fe_state_t;

    fe_state_t state_reg;
    logic [63:0] hash_reg;
    logic at_start_reg;
    logic stopped_reg;
    logic invalid_reg;
    logic [7:0] char_reg;
    logic last_reg;
    logic do_hash_reg;
    hids_pkg::op_t op_reg;
    logic [55:0] prod_lo_reg;
    logic [31:0] prod_hi_reg;

    logic accept;
    logic first_ok;
    logic rest_ok;
    logic [63:0] hash_next;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    assign busy = (state_reg != FE_IDLE) || q_full;
    assign accept = start && !busy;
    assign first_ok = (key_char == 8'h5F) || is_letter(key_char);
    assign rest_ok = first_ok || is_digit(key_char);

    assign hash_next = (64'(prod_lo_reg) + {prod_hi_reg, 32'd0}) ^ {56'd0, char_reg};

    assign q_push = (state_reg == FE_FINISH) && (last_reg || (op_reg == hids_pkg::OP_CLEAR));
    always_comb begin
        q_job.op = op_reg;
        q_job.invalid = invalid_reg;
        if (invalid_reg) begin
            q_job.hash = '0;
        end else if (do_hash_reg) begin
            q_job.hash = hash_next;
        end else begin
            q_job.hash = hash_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            char_reg <= key_char;
            prod_lo_reg <= 56'(hash_reg[31:0]) * 56'(hids_pkg::HASH_MULT);
            prod_hi_reg <= hash_reg[63:32] * 32'(hids_pkg::HASH_MULT);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= FE_IDLE;
            hash_reg <= hids_pkg::HASH_SEED;
            at_start_reg <= 1'b1;
            stopped_reg <= 1'b0;
            invalid_reg <= 1'b0;
            last_reg <= 1'b0;
            do_hash_reg <= 1'b0;
            op_reg <= hids_pkg::OP_LOOKUP;
        end else begin
            case (state_reg)
                FE_IDLE:
                begin
                    if (accept) begin
                        last_reg <= key_last;
                        case (req_type)
                            hids_pkg::REQ_LOOKUP, hids_pkg::REQ_INSERT:
                            begin
                                op_reg <= (req_type == hids_pkg::REQ_INSERT) ?
                                          hids_pkg::OP_INSERT : hids_pkg::OP_LOOKUP;
                                state_reg <= FE_FINISH;
                                at_start_reg <= 1'b0;
                                if (at_start_reg) begin
                                    do_hash_reg <= first_ok;
                                    if (!first_ok) begin
                                        invalid_reg <= 1'b1;
                                        stopped_reg <= 1'b1;
                                    end
                                end else begin
                                    do_hash_reg <= !stopped_reg && rest_ok;
                                    if (!rest_ok) begin
                                        stopped_reg <= 1'b1;
                                    end
                                end
                            end
                            hids_pkg::REQ_CLEAR:
                            begin
                                op_reg <= hids_pkg::OP_CLEAR;
                                state_reg <= FE_FINISH;
                                do_hash_reg <= 1'b0;
                                hash_reg <= hids_pkg::HASH_SEED;
                                at_start_reg <= 1'b1;
                                stopped_reg <= 1'b0;
                                invalid_reg <= 1'b0;
                            end
                            default:
                            begin
                                state_reg <= FE_IDLE;
                            end
                        endcase
                    end
                end
                FE_FINISH:
                begin
                    state_reg <= FE_IDLE;
                    if (last_reg && (op_reg != hids_pkg::OP_CLEAR)) begin
                        hash_reg <= hids_pkg::HASH_SEED;
                        at_start_reg <= 1'b1;
                        stopped_reg <= 1'b0;
                        invalid_reg <= 1'b0;
                    end else if (do_hash_reg) begin
                        hash_reg <= hash_next;
                    end
                end
                default:
                begin
                    state_reg <= FE_IDLE;
                end
            endcase
        end
    end

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("front pushed an item into a full queue");

    a_invalid_stops: assert property (@(posedge clk) disable iff (!rst_n)
        invalid_reg |-> stopped_reg && !at_start_reg)
        else $error("invalid key left hashing enabled");

endmodule

// ----- hdl/hids_back.sv -----
module hids_back (
    input  logic clk,
    input  logic rst_n,
    input  logic q_empty,
    input  hids_pkg::job_t q_job,
    output logic q_pop,
    output logic done,
    output logic found,
    output logic key_invalid,
    output logic table_full,
    output logic [63:0] key_hash
);

    typedef enum logic [1:0] {
        BE_IDLE = 2'b01,
        BE_SCAN = 2'b10
    } be_state_t;

    logic [63:0] mem [hids_pkg::TABLE_DEPTH];
    logic [63:0] rd_data_reg;

    be_state_t state_reg;
    logic [hids_pkg::CNT_W-1:0] cnt_reg;
    logic [hids_pkg::CNT_W-1:0] idx_reg;
    logic [63:0] cur_hash_reg;
    logic cur_invalid_reg;
    logic cmp_vld_reg;
    logic cmp_last_reg;
    logic done_reg;
    logic found_reg;
    logic invalid_reg;
    logic full_reg;
    logic [63:0] hash_reg;

    logic tbl_full;
    logic mem_we;
    logic rd_en;

    assign tbl_full = (cnt_reg == hids_pkg::CNT_W'(hids_pkg::TABLE_DEPTH));
    assign q_pop = (state_reg == BE_IDLE) && !q_empty;
    assign mem_we = q_pop && (q_job.op == hids_pkg::OP_INSERT) && !tbl_full;
    assign rd_en = (state_reg == BE_SCAN) && (idx_reg < cnt_reg);

    assign done = done_reg;
    assign found = found_reg;
    assign key_invalid = invalid_reg;
    assign table_full = full_reg;
    assign key_hash = hash_reg;

    always_ff @(posedge clk) begin
        if (mem_we) begin
            mem[cnt_reg[hids_pkg::ADDR_W-1:0]] <= q_job.hash;
        end
        if (rd_en) begin
            rd_data_reg <= mem[idx_reg[hids_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk) begin
        if (q_pop) begin
            cur_hash_reg <= q_job.hash;
            cur_invalid_reg <= q_job.invalid;
        end
        if (rd_en) begin
            cmp_last_reg <= ((idx_reg + 1'b1) == cnt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= BE_IDLE;
            cnt_reg <= '0;
            idx_reg <= '0;
            cmp_vld_reg <= 1'b0;
            done_reg <= 1'b0;
            found_reg <= 1'b0;
            invalid_reg <= 1'b0;
            full_reg <= 1'b0;
            hash_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                BE_IDLE:
                begin
                    if (q_pop) begin
                        case (q_job.op)
                            hids_pkg::OP_CLEAR:
                            begin
                                cnt_reg <= '0;
                            end
                            hids_pkg::OP_INSERT:
                            begin
                                done_reg <= 1'b1;
                                found_reg <= 1'b0;
                                invalid_reg <= q_job.invalid;
                                full_reg <= tbl_full;
                                hash_reg <= q_job.hash;
                                if (!tbl_full) begin
                                    cnt_reg <= cnt_reg + 1'b1;
                                end
                            end
                            hids_pkg::OP_LOOKUP:
                            begin
                                if ((q_job.hash == '0) || (cnt_reg == '0)) begin
                                    done_reg <= 1'b1;
                                    found_reg <= 1'b0;
                                    invalid_reg <= q_job.invalid;
                                    full_reg <= 1'b0;
                                    hash_reg <= q_job.hash;
                                end else begin
                                    idx_reg <= '0;
                                    cmp_vld_reg <= 1'b0;
                                    state_reg <= BE_SCAN;
                                end
                            end
                            default:
                            begin
                                state_reg <= BE_IDLE;
                            end
                        endcase
                    end
                end
                BE_SCAN:
                begin
                    cmp_vld_reg <= rd_en;
                    if (rd_en) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    if (cmp_vld_reg &&
                        ((rd_data_reg == cur_hash_reg) || cmp_last_reg)) begin
                        done_reg <= 1'b1;
                        found_reg <= (rd_data_reg == cur_hash_reg);
                        invalid_reg <= cur_invalid_reg;
                        full_reg <= 1'b0;
                        hash_reg <= cur_hash_reg;
                        state_reg <= BE_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= BE_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= hids_pkg::CNT_W'(hids_pkg::TABLE_DEPTH))
        else $error("entry count ran past the table depth");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && full_reg |-> tbl_full)
        else $error("insert dropped while a slot was free");

    a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && found_reg |-> (hash_reg != '0) && !full_reg)
        else $error("lookup matched a zero hash");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 950;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0] req;
        logic [7:0] ch;
        logic last;
        logic typed;
        logic e_found;
        logic e_invalid;
        logic e_full;
        logic [63:0] e_hash;
    } stim_row_t;

    typedef struct packed {
        logic found;
        logic invalid;
        logic full;
        logic [63:0] hash;
    } key_result_t;

    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0] len;
    } saved_key_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [1:0] req_type;
    logic [7:0] key_char;
    logic key_last;
    logic done;
    logic found;
    logic key_invalid;
    logic table_full;
    logic [63:0] key_hash;

    hashed_identifier_set u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req_type(req_type),
        .key_char(key_char),
        .key_last(key_last),
        .done(done),
        .found(found),
        .key_invalid(key_invalid),
        .table_full(table_full),
        .key_hash(key_hash)
    );

    logic [63:0] table_copy [hids_pkg::TABLE_DEPTH];
    int table_fill;
    logic [63:0] run_hash;
    logic at_first;
    logic hash_halted;
    logic bad_first;

    key_result_t pending_results [$];
    stim_row_t plan [$];
    saved_key_t key_pool [$];
    logic [7:0] word_buf [$];

    int mismatches;
    int results_seen;
    int hits_seen;
    int invalid_seen;
    int drops_seen;
    int bytes_sent;
    int clears_sent;
    int fills_done;
    bit no_idle;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic stim_row_t step(logic [1:0] r, logic [7:0] c, logic l);
        stim_row_t s;
        s = '0;
        s.req = r;
        s.ch = c;
        s.last = l;
        return s;
    endfunction

    function automatic stim_row_t known(logic [1:0] r, logic [7:0] c, logic l,
                                        logic f, logic inv, logic full, logic [63:0] h);
        stim_row_t s;
        s = step(r, c, l);
        s.typed = 1'b1;
        s.e_found = f;
        s.e_invalid = inv;
        s.e_full = full;
        s.e_hash = h;
        return s;
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic first_ok(logic [7:0] c);
        return c == "_" || is_letter(c);
    endfunction

    function automatic logic rest_ok(logic [7:0] c);
        return first_ok(c) || (c >= "0" && c <= "9");
    endfunction

    function automatic logic [7:0] pick_first();
        int r;
        r = $urandom_range(0, 52);
        if (r == 52)
            return "_";
        else if (r < 26)
            return 8'("A" + r);
        return 8'("a" + r - 26);
    endfunction

    function automatic logic [7:0] pick_rest();
        int r;
        r = $urandom_range(0, 62);
        if (r >= 53)
            return 8'("0" + r - 53);
        else if (r == 52)
            return "_";
        else if (r < 26)
            return 8'("A" + r);
        return 8'("a" + r - 26);
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic restart_key();
        run_hash = hids_pkg::HASH_SEED;
        at_first = 1'b1;
        hash_halted = 1'b0;
        bad_first = 1'b0;
    endtask

    task automatic predict(input stim_row_t s);
        key_result_t e;
        logic [63:0] h;
        logic hit;
        if (s.req == REQ_UNUSED)
            return;
        if (s.req == hids_pkg::REQ_CLEAR)
        begin
            for (int i = 0; i < hids_pkg::TABLE_DEPTH; i++)
                table_copy[i] = '0;
            table_fill = 0;
            restart_key();
            return;
        end
        if (at_first)
        begin
            at_first = 1'b0;
            if (first_ok(s.ch))
                run_hash = (run_hash * {40'd0, hids_pkg::HASH_MULT}) ^ {56'd0, s.ch};
            else
            begin
                bad_first = 1'b1;
                hash_halted = 1'b1;
            end
        end
        else if (!hash_halted)
        begin
            if (rest_ok(s.ch))
                run_hash = (run_hash * {40'd0, hids_pkg::HASH_MULT}) ^ {56'd0, s.ch};
            else
                hash_halted = 1'b1;
        end
        if (!s.last)
            return;
        h = bad_first ? 64'd0 : run_hash;
        hit = 1'b0;
        e.full = 1'b0;
        if (s.req == hids_pkg::REQ_LOOKUP)
        begin
            if (h != 64'd0)
                for (int i = 0; i < hids_pkg::TABLE_DEPTH; i++)
                    if (table_copy[i] != 64'd0 && table_copy[i] == h)
                        hit = 1'b1;
        end
        else if (table_fill >= hids_pkg::TABLE_DEPTH)
            e.full = 1'b1;
        else
        begin
            table_copy[table_fill] = h;
            table_fill++;
        end
        e.found = hit;
        e.invalid = bad_first;
        e.hash = h;
        if (s.typed)
        begin
            e.found = s.e_found;
            e.invalid = s.e_invalid;
            e.full = s.e_full;
            e.hash = s.e_hash;
        end
        pending_results.push_back(e);
        restart_key();
    endtask

    task automatic send_item(input stim_row_t s);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        req_type <= s.req;
        key_char <= s.ch;
        key_last <= s.last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict(s);
        if (s.req == hids_pkg::REQ_CLEAR)
            clears_sent++;
    endtask

    task automatic send_word(input logic [1:0] end_req, input bit mixed);
        logic [1:0] r;
        for (int i = 0; i < word_buf.size(); i++)
        begin
            if (i != word_buf.size() - 1 && $urandom_range(0, 39) == 0)
                send_item(step(REQ_UNUSED, 8'($urandom), 1'($urandom)));
            r = end_req;
            if (mixed && i != word_buf.size() - 1)
                r = 2'($urandom_range(0, 1));
            send_item(step(r, word_buf[i], i == word_buf.size() - 1));
            bytes_sent++;
        end
    endtask

    task automatic build_word(input int n);
        word_buf.delete();
        word_buf.push_back(pick_first());
        for (int i = 1; i < n; i++)
            word_buf.push_back(pick_rest());
    endtask

    task automatic remember_word();
        saved_key_t k;
        k = '0;
        k.len = 4'(word_buf.size());
        for (int i = 0; i < word_buf.size(); i++)
            k.bytes[8*i +: 8] = word_buf[i];
        key_pool.push_back(k);
    endtask

    task automatic recall_word();
        saved_key_t k;
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        word_buf.delete();
        for (int i = 0; i < k.len; i++)
            word_buf.push_back(k.bytes[8*i +: 8]);
    endtask

    task automatic fill_table();
        while (table_fill < hids_pkg::TABLE_DEPTH)
        begin
            build_word($urandom_range(1, 3));
            send_word(hids_pkg::REQ_INSERT, 1'b0);
            remember_word();
        end
        for (int i = 0; i < 4; i++)
        begin
            build_word($urandom_range(1, 4));
            send_word(hids_pkg::REQ_INSERT, 1'b0);
        end
        for (int i = 0; i < 6; i++)
        begin
            recall_word();
            send_word(hids_pkg::REQ_LOOKUP, 1'b0);
        end
        fills_done++;
    endtask

    always @(posedge clk)
    begin
        key_result_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Unexpected result: found=%0b invalid=%0b full=%0b hash=%h",
                             found, key_invalid, table_full, key_hash);
            end
            else
            begin
                e = pending_results.pop_front();
                results_seen++;
                hits_seen += e.found;
                invalid_seen += e.invalid;
                drops_seen += e.full;
                if (found !== e.found || key_invalid !== e.invalid ||
                    table_full !== e.full || key_hash !== e.hash)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $write("Mismatch at %0t: exp found=%0b invalid=%0b full=%0b hash=%h,",
                               $realtime, e.found, e.invalid, e.full, e.hash);
                        $display(" got found=%0b invalid=%0b full=%0b hash=%h",
                                 found, key_invalid, table_full, key_hash);
                    end
                end
            end
        end
    end

    initial
    begin
        int pick;
        int target;
        logic [7:0] bad_ch;
        rst_n = 1'b0;
        start = 1'b0;
        req_type = hids_pkg::REQ_LOOKUP;
        key_char = '0;
        key_last = 1'b0;
        mismatches = 0;
        results_seen = 0;
        hits_seen = 0;
        invalid_seen = 0;
        drops_seen = 0;
        bytes_sent = 0;
        clears_sent = 0;
        fills_done = 0;
        no_idle = 1'b0;
        for (int i = 0; i < hids_pkg::TABLE_DEPTH; i++)
            table_copy[i] = '0;
        table_fill = 0;
        restart_key();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        plan.push_back(known(hids_pkg::REQ_LOOKUP, "0", 1'b1, 1'b0, 1'b1, 1'b0, 64'd0));
        plan.push_back(known(hids_pkg::REQ_LOOKUP, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b0, 64'd0));
        plan.push_back(known(hids_pkg::REQ_INSERT, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 64'd0));
        plan.push_back(known(hids_pkg::REQ_LOOKUP, 8'h80, 1'b1, 1'b0, 1'b1, 1'b0, 64'd0));
        plan.push_back(step(hids_pkg::REQ_INSERT, "_", 1'b1));
        plan.push_back(step(hids_pkg::REQ_LOOKUP, "_", 1'b1));
        plan.push_back(step(hids_pkg::REQ_INSERT, "A", 1'b0));
        plan.push_back(step(hids_pkg::REQ_INSERT, "z", 1'b0));
        plan.push_back(step(hids_pkg::REQ_INSERT, "9", 1'b1));
        plan.push_back(step(hids_pkg::REQ_INSERT, "A", 1'b0));
        plan.push_back(step(hids_pkg::REQ_INSERT, "z", 1'b0));
        plan.push_back(step(hids_pkg::REQ_LOOKUP, "9", 1'b1));
        plan.push_back(step(hids_pkg::REQ_LOOKUP, "a", 1'b0));
        plan.push_back(step(hids_pkg::REQ_LOOKUP, "-", 1'b0));
        plan.push_back(step(hids_pkg::REQ_LOOKUP, "b", 1'b1));
        plan.push_back(step(hids_pkg::REQ_INSERT, "q", 1'b0));
        plan.push_back(step(hids_pkg::REQ_LOOKUP, 8'hFF, 1'b0));
        plan.push_back(step(hids_pkg::REQ_INSERT, "r", 1'b1));
        plan.push_back(step(hids_pkg::REQ_LOOKUP, "y", 1'b0));
        plan.push_back(step(REQ_UNUSED, 8'h55, 1'b1));
        plan.push_back(step(hids_pkg::REQ_LOOKUP, "y", 1'b1));
        plan.push_back(step(hids_pkg::REQ_LOOKUP, "x", 1'b0));
        plan.push_back(step(hids_pkg::REQ_CLEAR, 8'hAA, 1'b1));
        plan.push_back(step(hids_pkg::REQ_LOOKUP, "_", 1'b1));
        foreach (plan[i])
            send_item(plan[i]);

        target = bytes_sent + RANDOM_ITEMS;
        while (bytes_sent < target)
        begin
            no_idle = ($urandom_range(0, 99) < 15);
            if (fills_done == 0 && bytes_sent > target - RANDOM_ITEMS + 300)
            begin
                fill_table();
                continue;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                if ($urandom_range(0, 1) == 0 && key_pool.size() > 0 &&
                    $urandom_range(0, 9) < 6)
                begin
                    recall_word();
                    send_word(hids_pkg::REQ_LOOKUP, $urandom_range(0, 4) == 0);
                end
                else if ($urandom_range(0, 1) == 0)
                begin
                    build_word($urandom_range(1, 8));
                    send_word(hids_pkg::REQ_LOOKUP, $urandom_range(0, 4) == 0);
                end
                else
                begin
                    build_word($urandom_range(1, 8));
                    send_word(hids_pkg::REQ_INSERT, $urandom_range(0, 4) == 0);
                    remember_word();
                end
            end
            else if (pick < 82)
            begin
                word_buf.delete();
                for (int i = $urandom_range(1, 6); i > 0; i--)
                    word_buf.push_back(8'($urandom));
                send_word(2'($urandom_range(0, 1)), 1'b1);
            end
            else if (pick < 88)
            begin
                word_buf.delete();
                do
                    bad_ch = 8'($urandom);
                while (first_ok(bad_ch));
                word_buf.push_back(bad_ch);
                for (int i = $urandom_range(0, 4); i > 0; i--)
                    word_buf.push_back(pick_rest());
                send_word(2'($urandom_range(0, 1)), 1'b0);
            end
            else if (pick < 94)
            begin
                build_word($urandom_range(1, 3));
                do
                    bad_ch = 8'($urandom);
                while (rest_ok(bad_ch));
                word_buf.push_back(bad_ch);
                for (int i = $urandom_range(0, 3); i > 0; i--)
                    word_buf.push_back(8'($urandom));
                send_word(2'($urandom_range(0, 1)), 1'b0);
            end
            else if (pick < 97)
                send_item(step(REQ_UNUSED, 8'($urandom), 1'($urandom)));
            else
            begin
                send_item(step(hids_pkg::REQ_CLEAR, 8'($urandom), 1'($urandom)));
                bytes_sent++;
                key_pool.delete();
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (hids_pkg::TABLE_DEPTH + 16) @(posedge clk);

        $display("Sent %0d key bytes, checked %0d key results:",
                 bytes_sent, results_seen);
        $display("%0d hits, %0d invalid keys, %0d dropped inserts.",
                 hits_seen, invalid_seen, drops_seen);
        $display("The table was filled to capacity %0d time(s) and cleared %0d time(s).",
                 fills_done, clears_sent);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
